/* design/assert_macros.svh */
// Assertion macros used by the merge table core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// Expression must never be true outside reset.
`define ASSERT_NEVER(name, clk, rst, expr) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(name, clk, rst, prop)
`define ASSERT_NEVER(name, clk, rst, expr)
`endif
`endif

/* design/slmt_pkg.sv */
// Package with sizes, codes and helpers of the merge table.
`timescale 1ns / 1ps
package slmt_pkg;
  localparam int MAX_ELEMENTS = 1024;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int ECOUNT_W     = 11;
  localparam int INIT_W       = 10;
  localparam int TOTAL_W      = 11;
  localparam int SIZE_W       = 11;
  localparam int DIST_W       = 32;
  localparam int APB_W        = 32;
  localparam int PADDR_W      = 3;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [SIZE_W-1:0]  SIZE_MAX  = {SIZE_W{1'b1}};

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  localparam logic REG_ELEMENT_COUNT = 1'b0;
  localparam logic REG_INITIAL_MERGE = 1'b1;

  localparam logic [ECOUNT_W-1:0] ECOUNT_RESET = ECOUNT_W'(MAX_ELEMENTS);

  // Element count with zero read as one and large values clamped.
  function automatic logic [ECOUNT_W-1:0] live_count(input logic [ECOUNT_W-1:0] ec);
    logic [ECOUNT_W-1:0] n;
    if (ec == '0) begin
      n = ECOUNT_W'(1);
    end else if (ec > ECOUNT_W'(MAX_ELEMENTS)) begin
      n = ECOUNT_W'(MAX_ELEMENTS);
    end else begin
      n = ec;
    end
    return n;
  endfunction

  function automatic logic [ECOUNT_W-1:0] clusters_left_of(
    input logic [ECOUNT_W-1:0] n,
    input logic [TOTAL_W-1:0]  total
  );
    logic [ECOUNT_W-1:0] r;
    if (ECOUNT_W'(total) >= n) begin
      r = '0;
    end else begin
      r = n - ECOUNT_W'(total);
    end
    return r;
  endfunction
endpackage

/* design/slmt_ram.sv */
// Simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module slmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* design/single_linkage_merge_table_core.sv */
// Top level of the single-linkage merge table: registers, sequencer, label walk.
//
//  channel   handshake            payload
//  --------  -------------------  ------------------------------------------------
//  input     start && !busy       member_a, member_b, distance_bits
//  result    done (one cycle)     status, clusters_left, kept_label,
//                                 absorbed_label, edge_distance
//  config    APB write, pready=1  element_count (0x0), initial_merge_count (0x4)
//
// An item whose element is out of range is answered at the edge that accepts it.
// A merge reads both labels, walks the label memory over the element count
// in use, one entry per cycle, and then updates the cluster sizes; an edge
// within one cluster ends after the two label reads.
// After reset and after every register write a clearing pass over all MAX_ELEMENTS
// entries rebuilds the tables; busy stays high meanwhile.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module single_linkage_merge_table_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [slmt_pkg::IDX_W-1:0]    member_a,
  input  logic [slmt_pkg::IDX_W-1:0]    member_b,
  input  logic [slmt_pkg::DIST_W-1:0]   distance_bits,
  output logic                          done,
  output logic                          status,
  output logic [slmt_pkg::ECOUNT_W-1:0] clusters_left,
  output logic [slmt_pkg::IDX_W-1:0]    kept_label,
  output logic [slmt_pkg::IDX_W-1:0]    absorbed_label,
  output logic [slmt_pkg::DIST_W-1:0]   edge_distance,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [slmt_pkg::PADDR_W-1:0]  paddr,
  input  logic [slmt_pkg::APB_W-1:0]    pwdata,
  output logic [slmt_pkg::APB_W-1:0]    prdata,
  output logic                          pready
);
  import slmt_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RD_A, S_RD_B, S_WALK, S_SZ_RK, S_SZ_RG, S_SZ_WG
  } state_t;

  state_t               state;
  logic [IDX_W-1:0]     cnt;
  logic [ECOUNT_W-1:0]  element_count;
  logic [INIT_W-1:0]    initial_merge_count;
  logic [TOTAL_W-1:0]   total;
  logic [IDX_W-1:0]     b_reg;
  logic [DIST_W-1:0]    dist_reg;
  logic [IDX_W-1:0]     label_a;
  logic [IDX_W-1:0]     keep;
  logic [IDX_W-1:0]     gone;
  logic [SIZE_W-1:0]    size_keep;

  logic                 cfg_wr;
  logic [ECOUNT_W-1:0]  n_live;
  logic                 out_of_range;
  logic                 walk_last;
  logic [TOTAL_W-1:0]   total_inc;
  logic [SIZE_W:0]      size_sum;

  logic                 lab_we;
  logic [IDX_W-1:0]     lab_waddr;
  logic [IDX_W-1:0]     lab_wdata;
  logic [IDX_W-1:0]     lab_raddr;
  logic [IDX_W-1:0]     lab_rdata;
  logic                 size_we;
  logic [IDX_W-1:0]     size_waddr;
  logic [SIZE_W-1:0]    size_wdata;
  logic [IDX_W-1:0]     size_raddr;
  logic [SIZE_W-1:0]    size_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign busy   = (state != S_IDLE);

  always_comb begin
    unique case (paddr[2])
      REG_ELEMENT_COUNT: prdata = APB_W'(element_count);
      REG_INITIAL_MERGE: prdata = APB_W'(initial_merge_count);
      default:           prdata = '0;
    endcase
  end

  assign n_live       = live_count(element_count);
  assign out_of_range = (ECOUNT_W'(member_a) >= n_live) || (ECOUNT_W'(member_b) >= n_live);
  assign walk_last    = (ECOUNT_W'(cnt) == n_live - ECOUNT_W'(1));
  assign total_inc    = (total == TOTAL_MAX) ? total : total + TOTAL_W'(1);
  assign size_sum     = {1'b0, size_keep} + {1'b0, size_rdata};

  // Label memory: the walk reads entry cnt+1 while it rewrites entry cnt.
  always_comb begin
    lab_we    = 1'b0;
    lab_waddr = cnt;
    lab_wdata = keep;
    unique case (state)
      S_CLEAR: begin
        lab_we    = 1'b1;
        lab_wdata = cnt;
      end
      S_WALK:  lab_we = (lab_rdata == gone);
      default: lab_we = 1'b0;
    endcase
  end

  always_comb begin
    unique case (state)
      S_IDLE:  lab_raddr = member_a;
      S_RD_A:  lab_raddr = b_reg;
      S_RD_B:  lab_raddr = '0;
      default: lab_raddr = cnt + IDX_W'(1);
    endcase
  end

  always_comb begin
    size_we    = 1'b0;
    size_waddr = cnt;
    size_wdata = SIZE_W'(1);
    unique case (state)
      S_CLEAR: size_we = 1'b1;
      S_SZ_RG: begin
        size_we    = 1'b1;
        size_waddr = keep;
        size_wdata = size_sum[SIZE_W] ? SIZE_MAX : size_sum[SIZE_W-1:0];
      end
      S_SZ_WG: begin
        size_we    = 1'b1;
        size_waddr = gone;
        size_wdata = '0;
      end
      default: size_we = 1'b0;
    endcase
  end

  assign size_raddr = (state == S_SZ_RK) ? gone : keep;

  slmt_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ELEMENTS)) u_label_ram (
    .clk   (clk),
    .we    (lab_we),
    .waddr (lab_waddr),
    .wdata (lab_wdata),
    .raddr (lab_raddr),
    .rdata (lab_rdata)
  );

  slmt_ram #(.WIDTH(SIZE_W), .DEPTH(MAX_ELEMENTS)) u_size_ram (
    .clk   (clk),
    .we    (size_we),
    .waddr (size_waddr),
    .wdata (size_wdata),
    .raddr (size_raddr),
    .rdata (size_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_CLEAR;
      cnt                 <= '0;
      element_count       <= ECOUNT_RESET;
      initial_merge_count <= '0;
      total               <= '0;
      done                <= 1'b0;
    end else if (cfg_wr) begin
      // A register write restarts the tables with a fresh clearing pass.
      unique case (paddr[2])
        REG_ELEMENT_COUNT: element_count       <= pwdata[ECOUNT_W-1:0];
        REG_INITIAL_MERGE: initial_merge_count <= pwdata[INIT_W-1:0];
        default:           element_count       <= element_count;
      endcase
      state <= S_CLEAR;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          done  <= 1'b0;
          total <= TOTAL_W'(initial_merge_count);
          cnt   <= cnt + IDX_W'(1);
          if (cnt == IDX_W'(MAX_ELEMENTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          done <= start && out_of_range;
          if (start) begin
            b_reg    <= member_b;
            dist_reg <= distance_bits;
            if (out_of_range) begin
              status         <= STATUS_RANGE;
              clusters_left  <= clusters_left_of(n_live, total);
              kept_label     <= '0;
              absorbed_label <= '0;
              edge_distance  <= distance_bits;
            end else begin
              state <= S_RD_A;
            end
          end
        end
        S_RD_A: begin
          done    <= 1'b0;
          label_a <= lab_rdata;
          state   <= S_RD_B;
        end
        S_RD_B: begin
          done <= 1'b0;
          if (label_a == lab_rdata) begin
            state <= S_IDLE;
          end else begin
            keep  <= (label_a < lab_rdata) ? label_a : lab_rdata;
            gone  <= (label_a < lab_rdata) ? lab_rdata : label_a;
            cnt   <= '0;
            state <= S_WALK;
          end
        end
        S_WALK: begin
          done <= 1'b0;
          cnt  <= cnt + IDX_W'(1);
          if (walk_last) begin
            state <= S_SZ_RK;
          end
        end
        S_SZ_RK: begin
          done      <= 1'b0;
          size_keep <= size_rdata;
          state     <= S_SZ_RG;
        end
        S_SZ_RG: begin
          done  <= 1'b0;
          state <= S_SZ_WG;
        end
        S_SZ_WG: begin
          total          <= total_inc;
          done           <= 1'b1;
          status         <= STATUS_OK;
          clusters_left  <= clusters_left_of(n_live, total_inc);
          kept_label     <= keep;
          absorbed_label <= gone;
          edge_distance  <= dist_reg;
          state          <= S_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_CLK(a_merge_order, clk, rst,
    (done && status == STATUS_OK) |-> (kept_label < absorbed_label))
  `ASSERT_CLK(a_walk_bound, clk, rst,
    (state == S_WALK) |-> (ECOUNT_W'(cnt) < n_live))
  `ASSERT_CLK(a_accept_reads, clk, rst,
    (state == S_IDLE && start && !out_of_range && !cfg_wr) |=> (state == S_RD_A))
  `ASSERT_CLK(a_total_held, clk, rst,
    (state != S_CLEAR && state != S_SZ_WG) |=> $stable(total))
  `ASSERT_NEVER(a_busy_result, clk, rst,
    done && status == STATUS_RANGE && $past(state) != S_IDLE)
endmodule

/* sim/tb_single_linkage_merge_table_core.sv */
// Self-checking testbench for the single-linkage merge table core.
`timescale 1ns / 1ps
module tb_single_linkage_merge_table_core;
  import slmt_pkg::*;

  typedef struct {
    logic                status;
    logic [ECOUNT_W-1:0] left;
    logic [IDX_W-1:0]    kept;
    logic [IDX_W-1:0]    absorbed;
    logic [DIST_W-1:0]   distance;
  } merge_rec_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [IDX_W-1:0]    member_a = '0;
  logic [IDX_W-1:0]    member_b = '0;
  logic [DIST_W-1:0]   distance_bits = '0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [APB_W-1:0]    pwdata = '0;
  logic                busy;
  logic                done;
  logic                status;
  logic [ECOUNT_W-1:0] clusters_left;
  logic [IDX_W-1:0]    kept_label;
  logic [IDX_W-1:0]    absorbed_label;
  logic [DIST_W-1:0]   edge_distance;
  logic [APB_W-1:0]    prdata;
  logic                pready;

  // Shadow copy of the label table and the registers.
  logic [IDX_W-1:0]    label_map [MAX_ELEMENTS];
  logic [TOTAL_W-1:0]  merges_done;
  logic [ECOUNT_W-1:0] cfg_elements;
  logic [INIT_W-1:0]   cfg_initial;

  merge_rec_t pending_merges[$];
  int fault_count = 0;
  int items_sent = 0;
  int merges_seen = 0;
  int range_seen = 0;
  int settings_run = 0;
  int burst_left = 0;

  single_linkage_merge_table_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .member_a(member_a), .member_b(member_b), .distance_bits(distance_bits),
    .done(done), .status(status), .clusters_left(clusters_left),
    .kept_label(kept_label), .absorbed_label(absorbed_label),
    .edge_distance(edge_distance),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #10000000;
    $display("simulation failed");
    $finish;
  end

  function automatic int active_elements();
    int n;
    n = int'(cfg_elements);
    if (n < 1) n = 1;
    if (n > MAX_ELEMENTS) n = MAX_ELEMENTS;
    return n;
  endfunction

  function automatic logic [ECOUNT_W-1:0] clusters_now();
    int n;
    n = active_elements();
    return (int'(merges_done) >= n) ? '0 : ECOUNT_W'(n - int'(merges_done));
  endfunction

  task automatic restart_shadow();
    for (int i = 0; i < MAX_ELEMENTS; i++) label_map[i] = IDX_W'(i);
    merges_done = TOTAL_W'(cfg_initial);
  endtask

  // Works out the record an accepted edge causes and updates the shadow table.
  task automatic predict_merge(input int a, input int b, input logic [DIST_W-1:0] d,
                               output bit emits, output merge_rec_t rec);
    int n;
    int keep;
    int gone;
    int t;
    n = active_elements();
    emits = 1'b1;
    rec.distance = d;
    rec.kept = '0;
    rec.absorbed = '0;
    if (a >= n || b >= n) begin
      rec.status = STATUS_RANGE;
      rec.left = clusters_now();
    end else begin
      keep = int'(label_map[a]);
      gone = int'(label_map[b]);
      if (keep > gone) begin
        t = keep;
        keep = gone;
        gone = t;
      end
      if (keep == gone) begin
        emits = 1'b0;
      end else begin
        for (int i = 0; i < n; i++) begin
          if (label_map[i] == IDX_W'(gone)) label_map[i] = IDX_W'(keep);
        end
        if (merges_done != TOTAL_MAX) merges_done = merges_done + TOTAL_W'(1);
        rec.status = STATUS_OK;
        rec.left = clusters_now();
        rec.kept = IDX_W'(keep);
        rec.absorbed = IDX_W'(gone);
      end
    end
  endtask

  task automatic log_fault(input string what);
    fault_count++;
    if (fault_count <= 10) $display("MISMATCH: %s", what);
  endtask

  // Every done strobe is matched against the oldest outstanding record.
  always @(posedge clk) begin
    merge_rec_t want;
    if (!rst && done) begin
      if (pending_merges.size() == 0) begin
        log_fault($sformatf("unexpected result status=%0d left=%0d kept=%0d absorbed=%0d",
                            status, clusters_left, kept_label, absorbed_label));
      end else begin
        want = pending_merges.pop_front();
        if (want.status == STATUS_OK) merges_seen++;
        else range_seen++;
        if (status !== want.status || clusters_left !== want.left ||
            kept_label !== want.kept || absorbed_label !== want.absorbed ||
            edge_distance !== want.distance) begin
          log_fault($sformatf(
            "exp st=%0d left=%0d kept=%0d abs=%0d d=%h, got st=%0d left=%0d kept=%0d abs=%0d d=%h",
            want.status, want.left, want.kept, want.absorbed, want.distance,
            status, clusters_left, kept_label, absorbed_label, edge_distance));
        end
      end
    end
  end

  task automatic send_edge(input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b,
                           input logic [DIST_W-1:0] d);
    bit emits;
    merge_rec_t rec;
    start <= 1'b1;
    member_a <= a;
    member_b <= b;
    distance_bits <= d;
    do @(posedge clk); while (busy);
    predict_merge(a, b, d, emits, rec);
    if (emits) pending_merges.insert(pending_merges.size(), rec);
    items_sent++;
    if (burst_left == 0) begin
      start <= 1'b0;
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5))
        @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // Lowers start and waits until the block has answered everything it was given.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_merges.size() != 0) @(posedge clk);
    // An edge inside one cluster gives no result but keeps the block busy briefly.
    repeat (16) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Register write, read back, then wait out the clearing pass it starts.
  task automatic write_register(input logic reg_sel, input logic [APB_W-1:0] value);
    logic [PADDR_W-1:0] addr;
    logic [APB_W-1:0] want;
    addr = {reg_sel, 2'b00};
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_sel == REG_ELEMENT_COUNT) begin
      cfg_elements = value[ECOUNT_W-1:0];
      want = APB_W'(cfg_elements);
    end else begin
      cfg_initial = value[INIT_W-1:0];
      want = APB_W'(cfg_initial);
    end
    restart_shadow();
    settings_run++;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want)
      log_fault($sformatf("register %0d read %h, expected %h", reg_sel, prdata, want));
    psel <= 1'b0;
    penable <= 1'b0;
    repeat (2) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_edge(10'd0, 10'd1023, 32'h0000_0000);
    send_edge(10'd1023, 10'd0, 32'hFFFF_FFFF);
    send_edge(10'd512, 10'd512, 32'h3F80_0000);
    drain_results();
  endtask

  task automatic test_small_table();
    write_register(REG_ELEMENT_COUNT, 32'd4);
    send_edge(10'd0, 10'd1, 32'h4000_0000);
    send_edge(10'd3, 10'd2, 32'h4040_0000);
    send_edge(10'd3, 10'd1, 32'h4080_0000);
    send_edge(10'd2, 10'd0, 32'h40A0_0000);
    send_edge(10'd4, 10'd0, 32'h7F80_0000);
    send_edge(10'd0, 10'd1023, 32'hAAAA_5555);
    drain_results();
  endtask

  task automatic test_merge_saturation();
    // With three merges counted up front, four elements run out of clusters.
    write_register(REG_INITIAL_MERGE, 32'd3);
    send_edge(10'd1, 10'd0, 32'h5555_AAAA);
    send_edge(10'd2, 10'd3, 32'h0000_0001);
    send_edge(10'd1, 10'd2, 32'h8000_0000);
    drain_results();
  endtask

  task automatic test_count_clamping();
    write_register(REG_ELEMENT_COUNT, 32'd0);
    send_edge(10'd0, 10'd0, 32'h1234_5678);
    send_edge(10'd0, 10'd1, 32'h8765_4321);
    drain_results();
    write_register(REG_INITIAL_MERGE, 32'hFFFF_FFFF);
    write_register(REG_ELEMENT_COUNT, 32'hFFFF_F7FF);
    send_edge(10'd1023, 10'd1, 32'hDEAD_BEEF);
    send_edge(10'd1, 10'd1023, 32'hCAFE_F00D);
    drain_results();
    write_register(REG_ELEMENT_COUNT, 32'd1);
    send_edge(10'd0, 10'd0, 32'h0F0F_0F0F);
    drain_results();
    write_register(REG_INITIAL_MERGE, 32'd0);
    write_register(REG_ELEMENT_COUNT, 32'd2);
    send_edge(10'd1, 10'd0, 32'hF0F0_F0F0);
    drain_results();
  endtask

  task automatic test_random_settings(input int target);
    int n;
    int count;
    int pick;
    int a;
    int b;
    bit wide;
    bit paused;
    paused = 1'b0;
    while (items_sent < target) begin
      pick = $urandom_range(0, 19);
      wide = (pick == 1);
      if (pick == 0) count = $urandom_range(0, 1);
      else if (wide) count = $urandom_range(0, 1) ? 2047 : 1024;
      else count = $urandom_range(2, 48);
      write_register(REG_ELEMENT_COUNT, {21'($urandom_range(0, 2097151)), 11'(count)});
      n = active_elements();
      pick = $urandom_range(0, 9);
      if (pick < 6) count = 0;
      else if (pick < 9) count = $urandom_range(0, n);
      else count = $urandom_range(0, 1023);
      write_register(REG_INITIAL_MERGE, {22'($urandom_range(0, 4194303)), 10'(count)});
      count = wide ? $urandom_range(8, 16) : $urandom_range(10, 40);
      for (int k = 0; k < count; k++) begin
        pick = $urandom_range(0, 99);
        a = $urandom_range(0, n - 1);
        b = $urandom_range(0, n - 1);
        if (pick >= 80 && pick < 90 && n < MAX_ELEMENTS) begin
          b = $urandom_range(n, MAX_ELEMENTS - 1);
          if ($urandom_range(0, 1)) begin
            a = b;
            b = $urandom_range(0, MAX_ELEMENTS - 1);
          end
        end else if (pick >= 90) begin
          b = a;
        end
        send_edge(IDX_W'(a), IDX_W'(b), $urandom);
        // Once mid-run the sender holds off until the block has caught up.
        if (!paused && settings_run > 8 && k == count / 2) begin
          drain_results();
          paused = 1'b1;
        end
      end
      drain_results();
    end
  endtask

  initial begin
    cfg_elements = ECOUNT_RESET;
    cfg_initial = '0;
    restart_shadow();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);
    test_reset_defaults();
    test_small_table();
    test_merge_saturation();
    test_count_clamping();
    test_random_settings(565);
    drain_results();
    repeat (32) @(posedge clk);
    $display("Sent %0d edges across %0d register writes.", items_sent, settings_run);
    $display("Checked %0d merge records and %0d range errors.", merges_seen, range_seen);
    if (fault_count == 0 && pending_merges.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("Faults: %0d, results still missing: %0d", fault_count, pending_merges.size());
      $display("simulation failed");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+design
design/slmt_pkg.sv
design/slmt_ram.sv
design/single_linkage_merge_table_core.sv
sim/tb_single_linkage_merge_table_core.sv
